// ===== hdl/cu_pkg.sv =====
// shared types, constants and binomial table builder for combination unranking
`timescale 1ns / 1ps
package cu_pkg;

    localparam int LEN_W   = 7;
    localparam int WORD_W  = 64;
    localparam int TBL_MAX = 64;
    localparam int MAX_LEN_DEF = 64;

    typedef logic [WORD_W-1:0] row_t [0:TBL_MAX];

    typedef struct packed {
        logic              vld;
        logic              err;
        logic [LEN_W-1:0]  n;
        logic [LEN_W-1:0]  k;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] pat;
    } cu_item_t;

    // row p of pascal's triangle, zero for j > p
    function automatic row_t binom_row(input int p);
        row_t r;
        row_t nxt;
        for (int j = 0; j <= TBL_MAX; j++) begin
            r[j] = '0;
        end
        r[0] = 64'd1;
        for (int i = 1; i <= p; i++) begin
            nxt[0] = 64'd1;
            for (int j = 1; j <= TBL_MAX; j++) begin
                nxt[j] = r[j-1] + r[j];
            end
            r = nxt;
        end
        return r;
    endfunction

endpackage

// ===== hdl/combination_unrank_core.sv =====
// top level of the lexicographic combination unranking pipeline
//
// usage:
//   s_ channel takes one item per request: word length n, ones count k and
//   a 1-based rank m. m_ channel returns one item per request: the m-th
//   n-bit word with k ones in lexicographic order (m_tdata) and an
//   out-of-range flag (m_tuser) raised for rank zero, rank above c(n,k)
//   or n above MAX_LEN; the word is then zero.
// pipeline: MAX_LEN + 1 registers, one at the entry and one stage per bit
//   position (each a table lookup, compare and subtract); the last stage
//   drives the m_ channel directly.
// throughput: one item per cycle unless the m_ channel stalls; every
//   position has its own stage and its own constant row of the binomial table.
// reset: aresetn low for one edge empties the pipeline; the binomial
//   table is constant logic and needs no fill.
// stall: when m_tready is low with a result waiting the whole pipeline
//   holds and s_tready drops; no item is lost or repeated.
`timescale 1ns / 1ps
module combination_unrank_core
    import cu_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // word_length[6:0], ones_count[13:7], rank[77:14], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // pattern[63:0]
    output logic [0:0]  m_tuser    // out_of_range[0]
);

    localparam logic [LEN_W-1:0] MAX_N = LEN_W'(MAX_LEN);

    cu_item_t chain [0:MAX_LEN];
    cu_item_t entry_next, entry_reg;
    logic     en;
    logic [LEN_W-1:0]  in_n, in_k;
    logic [WORD_W-1:0] in_m;

    // whole pipeline advances unless a finished item waits on a stalled sink
    assign en       = !chain[MAX_LEN].vld || m_tready;
    assign s_tready = en;

    assign in_n = s_tdata[6:0];
    assign in_k = s_tdata[13:7];
    assign in_m = s_tdata[77:14];

    // entry checks that need no table: long words, rank zero, empty word
    always_comb begin
        entry_next.vld = s_tvalid;
        entry_next.n   = in_n;
        entry_next.k   = in_k;
        entry_next.m   = in_m;
        entry_next.pat = '0;
        entry_next.err = (in_n > MAX_N) || (in_m == '0)
                       || (in_n == '0 && (in_k != '0 || in_m != 64'd1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.vld <= 1'b0;
        end else if (en) begin
            entry_reg <= entry_next;
        end
    end

    assign chain[0] = entry_reg;

    // stage i decides bit position MAX_LEN-1-i
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_pos
        cu_stage #(
            .POS (MAX_LEN - 1 - i)
        ) u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_item  (chain[i]),
            .out_item (chain[i+1])
        );
    end

    assign m_tvalid   = chain[MAX_LEN].vld;
    assign m_tdata    = chain[MAX_LEN].err ? '0 : chain[MAX_LEN].pat;
    assign m_tuser[0] = chain[MAX_LEN].err;

endmodule

// ===== hdl/cu_stage.sv =====
// one bit position of the unranking pipeline
`timescale 1ns / 1ps
module cu_stage
    import cu_pkg::*;
#(
    parameter int POS = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  cu_item_t in_item,
    output cu_item_t out_item
);

    localparam row_t ROW = binom_row(POS);
    localparam logic [LEN_W-1:0] POS_N = LEN_W'(POS);
    localparam logic [LEN_W-1:0] TOP_K = LEN_W'(TBL_MAX);

    cu_item_t item_reg, item_next;
    logic [WORD_W-1:0] c0, c1, total;
    logic [LEN_W-1:0]  km1;
    logic              active, first;

    always_comb begin
        km1    = in_item.k - LEN_W'(1);
        c0     = (in_item.k <= TOP_K) ? ROW[in_item.k] : '0;
        c1     = (in_item.k != '0 && km1 <= TOP_K) ? ROW[km1] : '0;
        total  = c0 + c1;
        active = POS_N < in_item.n;
        first  = (POS_N + LEN_W'(1)) == in_item.n;

        item_next = in_item;
        if (active) begin
            // first position checks the rank against c(n, k)
            if (first && in_item.m > total) begin
                item_next.err = 1'b1;
            end
            if (in_item.m > c0) begin
                item_next.m        = in_item.m - c0;
                item_next.pat[POS] = 1'b1;
                if (in_item.k != '0) begin
                    item_next.k = km1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg.vld <= 1'b0;
        end else if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_item = item_reg;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the combination unranking core
`timescale 1ns / 1ps
module tb;
    import cu_pkg::*;

    localparam int LAT       = 66;
    localparam int MAX_CYC   = 400000;
    localparam int RAND_ITEMS = 1630;

    typedef struct {
        logic [63:0] pattern;
        logic        out_of_range;
    } word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // word_length[6:0], ones_count[13:7], rank[77:14], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // pattern[63:0]
    logic [0:0]  m_tuser;   // out_of_range[0]

    logic [63:0] pascal [0:64][0:64];
    word_t       pending_words [$];
    int          errors;
    int          cycles;
    int          sent;
    int          received;
    int          hold_cycles;   // long receiver hold-off when nonzero
    bit          rx_random;

    combination_unrank_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > MAX_CYC) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic [63:0] choose(int i, int j);
        if (i > 64 || j > 64) return 64'd0;
        return pascal[i][j];
    endfunction

    // walk positions from the top, subtracting binomials where the bit is set
    function automatic word_t unrank(logic [6:0] n, logic [6:0] k, logic [63:0] m);
        word_t       w;
        int          kk;
        logic [63:0] c;
        w.pattern = '0;
        w.out_of_range = 1'b0;
        if (n > 64 || m == 0 || m > choose(int'(n), int'(k))) begin
            w.out_of_range = 1'b1;
            return w;
        end
        kk = int'(k);
        for (int p = int'(n) - 1; p >= 0; p--) begin
            c = choose(p, kk);
            if (m > c) begin
                m -= c;
                w.pattern[p] = 1'b1;
                if (kk > 0) kk--;
            end
        end
        return w;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("tb: mismatch %s got %h want %h", what, got, want);
    endtask

    // offers one item at a falling edge and returns at the falling edge after it is taken
    task automatic send_item(logic [6:0] n, logic [6:0] k, logic [63:0] m, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {2'b00, m, k, n};
        s_tvalid <= 1'b1;
        pending_words.push_back(unrank(n, k, m));
        sent++;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // receiver: random stall per item, or a long counted hold-off
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_random && !m_tready) begin
                stall = $urandom_range(16);
                repeat (stall) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (rx_random && m_tvalid) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // checker: compare every accepted result with the oldest expected word
    always @(posedge aclk) begin
        word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            received++;
            if (pending_words.size() == 0) begin
                report("unexpected item", m_tdata, 64'd0);
            end else begin
                want = pending_words.pop_front();
                if (m_tdata !== want.pattern) report("pattern", m_tdata, want.pattern);
                if (m_tuser[0] !== want.out_of_range)
                    report("out_of_range", 64'(m_tuser[0]), 64'(want.out_of_range));
            end
        end
    end

    // stops offering and waits for every expected result, ends at a falling edge
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic test_directed();
        send_item(7'd0, 7'd0, 64'd1, 0);        // empty word, only valid case
        send_item(7'd0, 7'd0, 64'd2, 0);
        send_item(7'd0, 7'd1, 64'd1, 0);        // k above n
        send_item(7'd5, 7'd2, 64'd0, 0);        // rank zero
        send_item(7'd5, 7'd2, 64'd1, 0);
        send_item(7'd5, 7'd2, 64'd10, 0);
        send_item(7'd5, 7'd2, 64'd11, 0);       // just past the count
        send_item(7'd64, 7'd32, choose(64, 32), 0);
        send_item(7'd64, 7'd32, choose(64, 32) + 1, 0);
        send_item(7'd64, 7'd0, 64'd1, 0);
        send_item(7'd64, 7'd64, 64'd1, 0);
        send_item(7'd64, 7'd1, 64'd64, 0);
        send_item(7'd64, 7'd63, 64'd64, 0);
        send_item(7'd65, 7'd0, 64'd1, 0);       // length above limit
        send_item(7'd127, 7'd127, '1, 0);
        send_item(7'd10, 7'd100, 64'd1, 0);     // ones count above limit
        send_item(7'd64, 7'd32, '1, 0);
        send_item(7'd1, 7'd1, 64'd1, 0);
        send_item(7'd1, 7'd0, 64'd1, 0);
        drain();
    endtask

    task automatic test_random();
        logic [6:0]  n, k;
        logic [63:0] m, total;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(9) == 0) begin
                n = 7'($urandom); k = 7'($urandom); m = {$urandom, $urandom};
            end else begin
                n = 7'($urandom_range(64));
                k = 7'($urandom_range(int'(n)));
                total = choose(int'(n), int'(k));
                case ($urandom_range(5))
                    0: m = 1;
                    1: m = total;
                    2: m = total + 1;
                    default: m = ({$urandom, $urandom} % total) + 1;
                endcase
            end
            send_item(n, k, m, 1);
            if (i == 400) begin
                hold_cycles = 300;            // block fills and stalls its input
            end
            if (i == 800) drain();            // sender pauses until all results arrive
        end
        drain();
    endtask

    initial begin
        for (int i = 0; i <= 64; i++) begin
            for (int j = 0; j <= 64; j++) pascal[i][j] = 64'd0;
            pascal[i][0] = 64'd1;
            for (int j = 1; j <= i; j++) pascal[i][j] = pascal[i-1][j-1] + pascal[i-1][j];
        end
        errors = 0; sent = 0; received = 0; hold_cycles = 0; rx_random = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        rx_random = 1;
        test_random();
        repeat (LAT + 10) @(posedge aclk);
        $display("tb: %0d items sent, %0d results checked, with edge ranks and stalls",
                 sent, received);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/cu_pkg.sv
hdl/cu_stage.sv
hdl/combination_unrank_core.sv
verif/tb.sv
